// File: rtl/jp1d_pkg.sv
`timescale 1ns / 1ps

package jp1d_pkg;

    // sizes
    localparam int MAX_UNKNOWNS = 64;
    localparam int FRAC_BITS    = 16;
    localparam int ADDR_W       = $clog2(MAX_UNKNOWNS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int DATA_W       = 32;
    localparam int STEP_W       = 31;
    localparam int ITER_W       = 16;
    localparam int TOL_W        = 31;
    localparam int CFG_W        = 31;
    localparam int CFG_ADDR_W   = 2;
    localparam int OUT_TDATA_W  = 56;

    // residual numerator |t| * 2^F, t = 2x[i] - x[i-1] - x[i+1]
    localparam int T_W          = DATA_W + 3;
    localparam int QUO_W        = T_W + FRAC_BITS;
    localparam int DIV_CNT_W    = $clog2(QUO_W);
    localparam int R_W          = QUO_W + 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_UNKNOWNS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITERATIONS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE      = 2'd3;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_SWEEP,
        S_UPD0,
        S_UPD1,
        S_UPD2,
        S_UPD3,
        S_RES0,
        S_RES1,
        S_RES2,
        S_RES3,
        S_DIV,
        S_RESR,
        S_RESM,
        S_RESQ,
        S_RESA,
        S_CHECK,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

endpackage

// File: rtl/jacobi_poisson_1d_solver_unit.sv
`timescale 1ns / 1ps

// Jacobi solver for the 1D Poisson system (diagonal 2/h, off-diagonals -1/h), signed
// Q16.16. Right-hand-side elements load one per cycle; the element with tlast starts
// the solve, during which the input stalls. Each sweep runs an update pass and then a
// residual pass, where the residual of every unknown goes through one shared bit-serial
// divider, followed by a convergence check. After the solve the n solution elements
// stream out in index order, each read only once the previous one is accepted and
// tagged with the sweep count and converged flag. The iterate lives in a ping-pong
// memory; reads before the first update are masked to zero, so no clearing is needed.
module jacobi_poisson_1d_solver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [jp1d_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [jp1d_pkg::CFG_W-1:0]          i_cfg_data,
    // rhs stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [jp1d_pkg::DATA_W-1:0]         s_axis_tdata,  // [31:0] rhs_value
    input  logic                                s_axis_tlast,  // rhs_last
    // solution stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] solution_value, [32] converged, [48:33] sweeps_done, [55:49] zero
    output logic [jp1d_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast   // solution_last
);
    import jp1d_pkg::*;

    t_state r_state, n_state;

    // config registers
    logic [CNT_W-1:0]   r_num;
    logic [STEP_W-1:0]  r_step;
    logic [ITER_W-1:0]  r_max;
    logic [TOL_W-1:0]   r_tol;

    // solve control
    logic [CNT_W-1:0]   r_load_idx;
    logic [CNT_W-1:0]   r_n;
    logic [STEP_W-1:0]  r_h;
    logic [2*TOL_W-1:0] r_tol2;
    logic [ITER_W-1:0]  r_sweep;
    logic               r_conv;
    logic               r_zero;
    logic               r_bank;
    logic [CNT_W-1:0]   r_idx;
    logic [63:0]        r_sum;
    logic               r_out_valid;

    // datapath
    logic signed [DATA_W-1:0]   r_na;
    logic signed [DATA_W-1:0]   r_xc;
    logic signed [DATA_W-1:0]   r_b;
    logic signed [DATA_W:0]     r_nsum;
    logic signed [62:0]         r_prod;
    logic                       r_neg;
    logic [QUO_W-1:0]           r_quo;
    logic [STEP_W-1:0]          r_rem;
    logic [DIV_CNT_W-1:0]       r_dcnt;
    logic signed [R_W-1:0]      r_r;
    logic                       r_big;
    logic [DATA_W-1:0]          r_mag;
    logic [63:0]                r_sq;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic                       r_out_last;

    // memories
    logic [DATA_W-1:0] r_rhs_mem [MAX_UNKNOWNS];
    logic [DATA_W-1:0] r_x_mem   [2*MAX_UNKNOWNS];
    logic [DATA_W-1:0] r_bq;
    logic [DATA_W-1:0] r_xq;

    logic                in_acc;
    logic                rhs_we;
    logic [ADDR_W:0]     x_raddr;
    logic                x_we;
    logic [DATA_W-1:0]   x_wdata;

    logic [CNT_W-1:0]    idx_m1, idx_p1;
    logic                has_prev, has_next, idx_last;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign rhs_we   = in_acc && (r_load_idx < CNT_W'(MAX_UNKNOWNS));
    assign idx_m1   = r_idx - CNT_W'(1);
    assign idx_p1   = r_idx + CNT_W'(1);
    assign has_prev = (r_idx != '0);
    assign has_next = (idx_p1 < r_n);
    assign idx_last = (idx_p1 == r_n);

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // rhs memory
    always_ff @(posedge i_clk) begin
        if (rhs_we) begin
            r_rhs_mem[r_load_idx[ADDR_W-1:0]] <= s_axis_tdata;
        end
        r_bq <= r_rhs_mem[r_idx[ADDR_W-1:0]];
    end

    // iterate memory, two banks
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_x_mem[{~r_bank, r_idx[ADDR_W-1:0]}] <= x_wdata;
        end
        r_xq <= r_x_mem[x_raddr];
    end

    // update arithmetic: floor((b*h + nsum*2^F) / 2^(F+1)), saturated
    logic signed [63:0] upd_s;
    logic signed [63:0] upd_sh;
    logic               upd_fits;
    assign upd_s    = $signed({r_prod[62], r_prod})
                    + $signed({{15{r_nsum[DATA_W]}}, r_nsum, {FRAC_BITS{1'b0}}});
    assign upd_sh   = upd_s >>> (FRAC_BITS + 1);
    assign upd_fits = (&upd_sh[63:DATA_W-1]) || !(|upd_sh[63:DATA_W-1]);
    always_comb begin
        if (upd_fits) begin
            x_wdata = upd_sh[DATA_W-1:0];
        end else if (upd_sh[63]) begin
            x_wdata = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            x_wdata = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // neighbor read data, masked at the edges and before the first update
    logic signed [DATA_W-1:0] xd_upd, xd_res;
    assign xd_upd = (has_next && !r_zero) ? r_xq : '0;
    assign xd_res = has_next ? r_xq : '0;

    // residual numerator
    logic signed [T_W-1:0] res_t;
    logic [T_W-1:0]        res_tabs;
    assign res_t = ($signed({{3{r_xc[DATA_W-1]}}, r_xc}) <<< 1)
                 - $signed({{3{r_na[DATA_W-1]}}, r_na})
                 - $signed({{3{xd_res[DATA_W-1]}}, xd_res});
    assign res_tabs = res_t[T_W-1] ? T_W'(-res_t) : T_W'(res_t);

    // divider step
    logic [STEP_W:0] div_rsh;
    logic            div_ge;
    logic [STEP_W:0] div_sub;
    assign div_rsh = {r_rem, r_quo[QUO_W-1]};
    assign div_ge  = (div_rsh >= {1'b0, r_h});
    assign div_sub = div_rsh - {1'b0, r_h};

    // quotient minus rhs, magnitude, square
    logic signed [R_W-1:0] res_q;
    logic signed [R_W-1:0] res_r;
    logic [R_W-1:0]        res_mag;
    logic [64:0]           acc_add;
    assign res_q   = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign res_r   = res_q - $signed({{(R_W-DATA_W){r_b[DATA_W-1]}}, r_b});
    assign res_mag = r_r[R_W-1] ? R_W'(-r_r) : R_W'(r_r);
    assign acc_add = {1'b0, r_sum} + {1'b0, r_sq};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory controls
    always_comb begin
        n_state = r_state;
        x_raddr = {r_bank, r_idx[ADDR_W-1:0]};
        x_we    = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && s_axis_tlast) n_state = S_INIT;
            end
            S_INIT: n_state = S_SWEEP;
            S_SWEEP: begin
                n_state = (r_sweep < r_max) ? S_UPD0 : S_OUT_RD;
            end
            S_UPD0: begin
                x_raddr = {r_bank, idx_m1[ADDR_W-1:0]};
                n_state = S_UPD1;
            end
            S_UPD1: begin
                x_raddr = {r_bank, idx_p1[ADDR_W-1:0]};
                n_state = S_UPD2;
            end
            S_UPD2: n_state = S_UPD3;
            S_UPD3: begin
                x_we    = 1'b1;
                n_state = idx_last ? S_RES0 : S_UPD0;
            end
            S_RES0: begin
                x_raddr = {~r_bank, idx_m1[ADDR_W-1:0]};
                n_state = S_RES1;
            end
            S_RES1: begin
                x_raddr = {~r_bank, r_idx[ADDR_W-1:0]};
                n_state = S_RES2;
            end
            S_RES2: begin
                x_raddr = {~r_bank, idx_p1[ADDR_W-1:0]};
                n_state = S_RES3;
            end
            S_RES3: n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == DIV_CNT_W'(QUO_W - 1)) n_state = S_RESR;
            end
            S_RESR: n_state = S_RESM;
            S_RESM: n_state = S_RESQ;
            S_RESQ: n_state = S_RESA;
            S_RESA: n_state = idx_last ? S_CHECK : S_RES0;
            S_CHECK: begin
                n_state = (r_sum < {2'b00, r_tol2}) ? S_OUT_RD : S_SWEEP;
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: n_state = S_OUT_HOLD;
            S_OUT_HOLD: begin
                if (m_axis_tready) n_state = r_out_last ? S_LOAD : S_OUT_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= CNT_W'(64);
            r_step      <= STEP_W'(1024);
            r_max       <= ITER_W'(1000);
            r_tol       <= TOL_W'(66);
            r_load_idx  <= '0;
            r_n         <= '0;
            r_h         <= '0;
            r_tol2      <= '0;
            r_sweep     <= '0;
            r_conv      <= 1'b0;
            r_zero      <= 1'b1;
            r_bank      <= 1'b0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NUM_UNKNOWNS:   r_num  <= i_cfg_data[CNT_W-1:0];
                    CFG_STEP_SIZE:      r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_MAX_ITERATIONS: r_max  <= i_cfg_data[ITER_W-1:0];
                    CFG_TOLERANCE:      r_tol  <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            // load counter
            if (in_acc) begin
                if (s_axis_tlast) begin
                    r_load_idx <= '0;
                end else if (rhs_we) begin
                    r_load_idx <= r_load_idx + CNT_W'(1);
                end
            end

            unique case (r_state)
                S_INIT: begin
                    if (r_num == '0) begin
                        r_n <= CNT_W'(1);
                    end else if (r_num > CNT_W'(MAX_UNKNOWNS)) begin
                        r_n <= CNT_W'(MAX_UNKNOWNS);
                    end else begin
                        r_n <= r_num;
                    end
                    r_h     <= (r_step == '0) ? STEP_W'(1) : r_step;
                    r_tol2  <= r_tol * r_tol;
                    r_sweep <= '0;
                    r_conv  <= 1'b0;
                    r_zero  <= 1'b1;
                    r_idx   <= '0;
                end
                S_SWEEP: begin
                    r_idx <= '0;
                    if (r_sweep < r_max) r_sweep <= r_sweep + ITER_W'(1);
                end
                S_UPD1: begin
                    r_na <= (has_prev && !r_zero) ? r_xq : '0;
                    r_b  <= r_bq;
                end
                S_UPD2: begin
                    r_nsum <= {r_na[DATA_W-1], r_na} + {xd_upd[DATA_W-1], xd_upd};
                    r_prod <= r_b * $signed({1'b0, r_h});
                end
                S_UPD3: begin
                    if (idx_last) begin
                        r_idx <= '0;
                        r_sum <= '0;
                    end else begin
                        r_idx <= idx_p1;
                    end
                end
                S_RES1: begin
                    r_na <= has_prev ? r_xq : '0;
                    r_b  <= r_bq;
                end
                S_RES2: r_xc <= r_xq;
                S_RES3: begin
                    r_neg  <= res_t[T_W-1];
                    r_quo  <= {res_tabs, {FRAC_BITS{1'b0}}};
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_sub[STEP_W-1:0] : div_rsh[STEP_W-1:0];
                    r_quo  <= {r_quo[QUO_W-2:0], div_ge};
                    r_dcnt <= r_dcnt + DIV_CNT_W'(1);
                end
                S_RESR: r_r <= res_r;
                S_RESM: begin
                    r_big <= |res_mag[R_W-1:DATA_W];
                    r_mag <= res_mag[DATA_W-1:0];
                end
                S_RESQ: r_sq <= r_big ? {64{1'b1}} : r_mag * r_mag;
                S_RESA: begin
                    r_sum <= acc_add[64] ? {64{1'b1}} : acc_add[63:0];
                    r_idx <= idx_last ? '0 : idx_p1;
                end
                S_CHECK: begin
                    r_idx <= '0;
                    if (r_sum < {2'b00, r_tol2}) begin
                        r_conv <= 1'b1;
                    end else begin
                        r_bank <= ~r_bank;
                        r_zero <= 1'b0;
                    end
                end
                S_OUT_LD: begin
                    r_out_data  <= {{(OUT_TDATA_W-ITER_W-1-DATA_W){1'b0}}, r_sweep, r_conv,
                                    (r_zero ? {DATA_W{1'b0}} : r_xq)};
                    r_out_last  <= idx_last;
                    r_out_valid <= 1'b1;
                end
                S_OUT_HOLD: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_idx       <= idx_p1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
